// File: rtl/ddvb_pkg.sv
// Shared types, constants and saturation helpers of the voxel backprojector.
package ddvb_pkg;

  localparam int DET_COLS_DEF = 512;
  localparam int DET_ROWS_DEF = 512;
  localparam int STORE_DEPTH  = 262144;
  localparam int ADDR_W       = 18;
  localparam int DATA_W       = 32;
  localparam int SUM_W        = 48;
  localparam int ACC_W        = 58;
  localparam int BIN_W        = 52;
  localparam int DIV_W        = 64;
  localparam int DVS_W        = 33;
  localparam int OPND_W       = 33;
  localparam int PROD_W       = 66;
  localparam int WID_W        = 18;
  localparam int CFG_IDX_W    = 3;

  localparam logic signed [31:0] HALF_Q16 = 32'sd32768;
  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIN_PHI    = 3'd0,
    CFG_COS_PHI    = 3'd1,
    CFG_SRC_DET    = 3'd2,
    CFG_SRC_AXIS   = 3'd3,
    CFG_COL_PITCH  = 3'd4,
    CFG_COL_OFFSET = 3'd5,
    CFG_ROW_PITCH  = 3'd6,
    CFG_ROW_OFFSET = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAPTURE,
    OP_ROT_MUL,
    OP_ROT_FIN,
    OP_POINT,
    OP_MUL_Y,
    OP_DIV_Y,
    OP_REC_Y,
    OP_MUL_Z,
    OP_DIV_Z,
    OP_REC_Z,
    OP_BIN_DIV,
    OP_BIN_REC,
    OP_WALK_INIT,
    OP_COL_INIT,
    OP_ROW_READ,
    OP_ROW_W,
    OP_ROW_MUL,
    OP_ROW_ACC,
    OP_COL_NEXT,
    OP_FINISH,
    OP_FINISH_ZERO
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic pitch_zero;
    logic den_bad;
    logic div_busy;
    logic col_go;
    logic row_go;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(48'sh7fffffffffff);
    lo = ACC_W'(48'sh800000000000);
    if (v > hi) begin
      return 48'sh7fffffffffff;
    end else if (v < lo) begin
      return 48'sh800000000000;
    end
    return v[SUM_W-1:0];
  endfunction

endpackage

// File: rtl/ddvb_div.sv
// Radix-2 restoring divider with floor rounding for a signed dividend.
module ddvb_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [ddvb_pkg::DIV_W-1:0] dividend,
  input  logic [ddvb_pkg::DVS_W-1:0]        divisor,
  output logic                             busy,
  output logic signed [ddvb_pkg::DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(ddvb_pkg::DIV_W);

  logic [ddvb_pkg::DIV_W-1:0] mag;
  logic [ddvb_pkg::DVS_W-1:0] rem;
  logic [ddvb_pkg::DVS_W-1:0] dvs;
  logic [ddvb_pkg::DVS_W:0]   trial;
  logic [CNT_W-1:0]           cnt;
  logic                       neg;
  logic                       take;

  assign trial = {rem, mag[ddvb_pkg::DIV_W-1]};
  assign take  = trial >= {1'b0, dvs};

  // floor: a negative quotient with a remainder steps one further down
  assign quotient = neg ? $signed(~mag + ddvb_pkg::DIV_W'(rem == '0)) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      neg  <= dividend[ddvb_pkg::DIV_W-1];
      mag  <= dividend[ddvb_pkg::DIV_W-1] ? ~dividend + 1'b1 : dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= take ? ddvb_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[ddvb_pkg::DVS_W-1:0];
      mag <= {mag[ddvb_pkg::DIV_W-2:0], take};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ddvb_pkg::DIV_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ddvb_ctrl.sv
// Sequencer that steps the datapath through one voxel.
module ddvb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              operation,
  input  logic              out_stall,
  input  ddvb_pkg::status_t status,
  output logic              in_stall,
  output logic              out_valid,
  output ddvb_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_ROT, S_ROT_FIN, S_PT, S_PT_CHK,
    S_MUL_Y, S_DIV_Y, S_WAIT_Y, S_REC_Y, S_MUL_Z, S_DIV_Z, S_WAIT_Z, S_REC_Z,
    S_BIN_DIV, S_BIN_WAIT, S_BIN_REC, S_WALK_INIT, S_COL, S_COL_INIT,
    S_ROW, S_ROW_READ, S_ROW_W, S_ROW_MUL, S_ROW_ACC, S_DONE
  } state_t;

  state_t     state;
  logic [2:0] k;
  logic       zero;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd.idx = k;
    cmd.op  = ddvb_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = operation ? ddvb_pkg::OP_CAPTURE : ddvb_pkg::OP_LOAD;
        end
      end
      S_ROT:       cmd.op = ddvb_pkg::OP_ROT_MUL;
      S_ROT_FIN:   cmd.op = ddvb_pkg::OP_ROT_FIN;
      S_PT:        cmd.op = ddvb_pkg::OP_POINT;
      S_MUL_Y:     cmd.op = ddvb_pkg::OP_MUL_Y;
      S_DIV_Y:     cmd.op = ddvb_pkg::OP_DIV_Y;
      S_REC_Y:     cmd.op = ddvb_pkg::OP_REC_Y;
      S_MUL_Z:     cmd.op = ddvb_pkg::OP_MUL_Z;
      S_DIV_Z:     cmd.op = ddvb_pkg::OP_DIV_Z;
      S_REC_Z:     cmd.op = ddvb_pkg::OP_REC_Z;
      S_BIN_DIV:   cmd.op = ddvb_pkg::OP_BIN_DIV;
      S_BIN_REC:   cmd.op = ddvb_pkg::OP_BIN_REC;
      S_WALK_INIT: cmd.op = ddvb_pkg::OP_WALK_INIT;
      S_COL_INIT:  cmd.op = ddvb_pkg::OP_COL_INIT;
      S_ROW: begin
        if (!status.row_go) begin
          cmd.op = ddvb_pkg::OP_COL_NEXT;
        end
      end
      S_ROW_READ:  cmd.op = ddvb_pkg::OP_ROW_READ;
      S_ROW_W:     cmd.op = ddvb_pkg::OP_ROW_W;
      S_ROW_MUL:   cmd.op = ddvb_pkg::OP_ROW_MUL;
      S_ROW_ACC:   cmd.op = ddvb_pkg::OP_ROW_ACC;
      S_DONE: begin
        if (slot_free) begin
          cmd.op = zero ? ddvb_pkg::OP_FINISH_ZERO : ddvb_pkg::OP_FINISH;
        end
      end
      default:     cmd.op = ddvb_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      zero      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && operation) begin
            state <= S_START;
          end
        end
        S_START: begin
          k    <= '0;
          zero <= status.pitch_zero;
          state <= status.pitch_zero ? S_DONE : S_ROT;
        end
        S_ROT: begin
          k <= k + 1'b1;
          if (k == 3'd3) begin
            state <= S_ROT_FIN;
          end
        end
        S_ROT_FIN: begin
          k     <= '0;
          state <= S_PT;
        end
        S_PT:     state <= S_PT_CHK;
        S_PT_CHK: begin
          // point at or behind the source: result is zero
          if (status.den_bad) begin
            zero  <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_MUL_Y;
          end
        end
        S_MUL_Y:  state <= S_DIV_Y;
        S_DIV_Y:  state <= S_WAIT_Y;
        S_WAIT_Y: begin
          if (!status.div_busy) begin
            state <= S_REC_Y;
          end
        end
        S_REC_Y:  state <= S_MUL_Z;
        S_MUL_Z:  state <= S_DIV_Z;
        S_DIV_Z:  state <= S_WAIT_Z;
        S_WAIT_Z: begin
          if (!status.div_busy) begin
            state <= S_REC_Z;
          end
        end
        S_REC_Z: begin
          if (k == 3'd5) begin
            k     <= '0;
            state <= S_BIN_DIV;
          end else begin
            k     <= k + 1'b1;
            state <= S_PT;
          end
        end
        S_BIN_DIV:  state <= S_BIN_WAIT;
        S_BIN_WAIT: begin
          if (!status.div_busy) begin
            state <= S_BIN_REC;
          end
        end
        S_BIN_REC: begin
          if (k == 3'd3) begin
            state <= S_WALK_INIT;
          end else begin
            k     <= k + 1'b1;
            state <= S_BIN_DIV;
          end
        end
        S_WALK_INIT: state <= S_COL;
        S_COL:       state <= status.col_go ? S_COL_INIT : S_DONE;
        S_COL_INIT:  state <= S_ROW;
        S_ROW:       state <= status.row_go ? S_ROW_READ : S_COL;
        S_ROW_READ:  state <= S_ROW_W;
        S_ROW_W:     state <= S_ROW_MUL;
        S_ROW_MUL:   state <= S_ROW_ACC;
        S_ROW_ACC:   state <= S_ROW;
        S_DONE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ddvb_datapath.sv
// Registers, detector store, shared multiplier and divider of the backprojector.
module ddvb_datapath #(
  parameter int DET_COLS = ddvb_pkg::DET_COLS_DEF,
  parameter int DET_ROWS = ddvb_pkg::DET_ROWS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [ddvb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                           cfg_wdata,
  input  logic [ddvb_pkg::ADDR_W-1:0]           det_index,
  input  logic signed [31:0]                    sample_value,
  input  logic signed [31:0]                    voxel_x,
  input  logic signed [31:0]                    voxel_y,
  input  logic signed [31:0]                    voxel_z,
  input  ddvb_pkg::cmd_t                        cmd,
  output ddvb_pkg::status_t                     status,
  output logic signed [ddvb_pkg::SUM_W-1:0]     voxel_sum
);

  localparam int BW    = ddvb_pkg::BIN_W;
  localparam int IA_W  = $clog2(DET_COLS) + 1;
  localparam int IB_W  = $clog2(DET_ROWS) + 1;
  localparam int AW    = ddvb_pkg::ADDR_W;
  localparam int PW    = ddvb_pkg::PROD_W;
  localparam int OW    = ddvb_pkg::OPND_W;
  localparam logic signed [BW-1:0] COLS_HALF = BW'((DET_COLS / 2) * 65536);
  localparam logic signed [BW-1:0] ROWS_HALF = BW'((DET_ROWS / 2) * 65536);
  localparam logic signed [BW-1:0] COLS_B    = BW'(DET_COLS);
  localparam logic signed [BW-1:0] ROWS_B    = BW'(DET_ROWS);
  localparam logic signed [BW-1:0] ONE_B     = BW'(65536);
  localparam logic [AW-1:0]        COLS_A    = AW'(DET_COLS);

  // configuration
  logic signed [31:0] sin_phi, cos_phi, col_offset, row_offset;
  logic [30:0]        sid, sad, col_pitch, row_pitch;
  logic signed [31:0] s_cl, c_cl;

  // voxel and geometry
  logic signed [31:0]   xc, yc, zc, xr, yr, px, py, pz, a_cur;
  logic signed [31:0]   amin, amax, bmin, bmax;
  logic signed [33:0]   den;
  logic signed [PW:0]   xsum, ysum, yfin;
  logic signed [BW-1:0] umin, umax, vmin, vmax;

  // walk
  logic [IA_W-1:0]      ia;
  logic [IB_W-1:0]      ib, ib_start;
  logic [AW-1:0]        addr;
  logic signed [ddvb_pkg::WID_W-1:0] wa, wb;
  logic signed [ddvb_pkg::ACC_W-1:0] acc;
  logic signed [BW-1:0] ia_q, ia1_q, ib_q, ib1_q, wa_full, wb_full;
  logic signed [BW-1:0] ua_fl, vb_fl;

  // store
  logic [31:0] store_mem [ddvb_pkg::STORE_DEPTH];
  logic [31:0] rd_data;

  // arithmetic units
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic                 mul_en;
  logic                 div_start, div_busy;
  logic signed [ddvb_pkg::DIV_W-1:0] div_n, div_q;
  logic [ddvb_pkg::DVS_W-1:0]        div_d;
  logic signed [31:0]   bin_pos, bin_off;
  logic [30:0]          bin_pitch;
  logic signed [32:0]   bin_diff;
  logic signed [31:0]   b_cur;
  logic signed [BW-1:0] bin_val;
  logic signed [32:0]   xm, xp, ym, yp, zm, zp;
  logic signed [31:0]   px_n, py_n, pz_n;

  assign s_cl = (sin_phi > ddvb_pkg::ONE_Q30) ? ddvb_pkg::ONE_Q30 :
                (sin_phi < -ddvb_pkg::ONE_Q30) ? -ddvb_pkg::ONE_Q30 : sin_phi;
  assign c_cl = (cos_phi > ddvb_pkg::ONE_Q30) ? ddvb_pkg::ONE_Q30 :
                (cos_phi < -ddvb_pkg::ONE_Q30) ? -ddvb_pkg::ONE_Q30 : cos_phi;

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_phi    <= '0;
      cos_phi    <= ddvb_pkg::ONE_Q30;
      sid        <= 31'd65536000;
      sad        <= 31'd32768000;
      col_pitch  <= 31'd65536;
      col_offset <= '0;
      row_pitch  <= 31'd65536;
      row_offset <= '0;
    end else if (cfg_wr_en) begin
      unique case (ddvb_pkg::cfg_reg_t'(cfg_index))
        ddvb_pkg::CFG_SIN_PHI:    sin_phi    <= cfg_wdata;
        ddvb_pkg::CFG_COS_PHI:    cos_phi    <= cfg_wdata;
        ddvb_pkg::CFG_SRC_DET:    sid        <= cfg_wdata[30:0];
        ddvb_pkg::CFG_SRC_AXIS:   sad        <= cfg_wdata[30:0];
        ddvb_pkg::CFG_COL_PITCH:  col_pitch  <= cfg_wdata[30:0];
        ddvb_pkg::CFG_COL_OFFSET: col_offset <= cfg_wdata;
        ddvb_pkg::CFG_ROW_PITCH:  row_pitch  <= cfg_wdata[30:0];
        ddvb_pkg::CFG_ROW_OFFSET: row_offset <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ddvb_pkg::OP_LOAD) begin
      store_mem[det_index] <= sample_value;
    end
    rd_data <= store_mem[addr];
  end

  // shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.op)
      ddvb_pkg::OP_ROT_MUL: begin
        unique case (cmd.idx)
          3'd0:    begin mul_a = {xc[31], xc}; mul_b = {c_cl[31], c_cl}; end
          3'd1:    begin mul_a = {yc[31], yc}; mul_b = {s_cl[31], s_cl}; end
          3'd2:    begin mul_a = {yc[31], yc}; mul_b = {c_cl[31], c_cl}; end
          default: begin mul_a = {xc[31], xc}; mul_b = {s_cl[31], s_cl}; end
        endcase
      end
      ddvb_pkg::OP_MUL_Y: begin mul_a = {2'b00, sid}; mul_b = {py[31], py}; end
      ddvb_pkg::OP_MUL_Z: begin mul_a = {2'b00, sid}; mul_b = {pz[31], pz}; end
      ddvb_pkg::OP_ROW_W: begin mul_a = OW'(wa); mul_b = OW'(wb); end
      ddvb_pkg::OP_ROW_MUL: begin
        mul_a = prod[OW+15:16];
        mul_b = {rd_data[31], rd_data};
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // divider operands
  always_comb begin
    bin_pos   = amin;
    bin_off   = col_offset;
    bin_pitch = col_pitch;
    unique case (cmd.idx)
      3'd0:    begin bin_pos = amin; bin_off = col_offset; bin_pitch = col_pitch; end
      3'd1:    begin bin_pos = amax; bin_off = col_offset; bin_pitch = col_pitch; end
      3'd2:    begin bin_pos = bmin; bin_off = row_offset; bin_pitch = row_pitch; end
      default: begin bin_pos = bmax; bin_off = row_offset; bin_pitch = row_pitch; end
    endcase
    bin_diff = {bin_pos[31], bin_pos} - {bin_off[31], bin_off};
    div_start = 1'b1;
    div_n     = prod[ddvb_pkg::DIV_W-1:0];
    div_d     = den[ddvb_pkg::DVS_W-1:0];
    unique case (cmd.op)
      ddvb_pkg::OP_DIV_Y, ddvb_pkg::OP_DIV_Z: ;
      ddvb_pkg::OP_BIN_DIV: begin
        div_n = ddvb_pkg::DIV_W'(bin_diff) <<< 16;
        div_d = {2'b00, bin_pitch};
      end
      default: div_start = 1'b0;
    endcase
  end

  ddvb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // face points
  assign xm = {xr[31], xr} - {ddvb_pkg::HALF_Q16[31], ddvb_pkg::HALF_Q16};
  assign xp = {xr[31], xr} + {ddvb_pkg::HALF_Q16[31], ddvb_pkg::HALF_Q16};
  assign ym = {yr[31], yr} - {ddvb_pkg::HALF_Q16[31], ddvb_pkg::HALF_Q16};
  assign yp = {yr[31], yr} + {ddvb_pkg::HALF_Q16[31], ddvb_pkg::HALF_Q16};
  assign zm = {zc[31], zc} - {ddvb_pkg::HALF_Q16[31], ddvb_pkg::HALF_Q16};
  assign zp = {zc[31], zc} + {ddvb_pkg::HALF_Q16[31], ddvb_pkg::HALF_Q16};

  always_comb begin
    unique case (cmd.idx)
      3'd0: begin
        px_n = ddvb_pkg::sat32(72'(xm)); py_n = ddvb_pkg::sat32(72'(ym)); pz_n = zc;
      end
      3'd1: begin
        px_n = ddvb_pkg::sat32(72'(xp)); py_n = ddvb_pkg::sat32(72'(yp)); pz_n = zc;
      end
      3'd2: begin
        px_n = ddvb_pkg::sat32(72'(xm)); py_n = ddvb_pkg::sat32(72'(yp)); pz_n = zc;
      end
      3'd3: begin
        px_n = ddvb_pkg::sat32(72'(xp)); py_n = ddvb_pkg::sat32(72'(ym)); pz_n = zc;
      end
      3'd4: begin
        px_n = xr; py_n = yr; pz_n = ddvb_pkg::sat32(72'(zp));
      end
      default: begin
        px_n = xr; py_n = yr; pz_n = ddvb_pkg::sat32(72'(zm));
      end
    endcase
  end

  assign yfin    = ysum - {prod[PW-1], prod};
  assign b_cur   = ddvb_pkg::sat32(72'(div_q));
  assign bin_val = BW'(div_q) + ((cmd.idx < 3'd2) ? COLS_HALF : ROWS_HALF);

  // footprint walk geometry
  assign ia_q    = BW'({ia, 16'h0000});
  assign ia1_q   = ia_q + ONE_B;
  assign ib_q    = BW'({ib, 16'h0000});
  assign ib1_q   = ib_q + ONE_B;
  assign wa_full = ((ia1_q < umax) ? ia1_q : umax) - ((ia_q > umin) ? ia_q : umin);
  assign wb_full = ((ib1_q < vmax) ? ib1_q : vmax) - ((ib_q > vmin) ? ib_q : vmin);
  assign ua_fl   = umin >>> 16;
  assign vb_fl   = vmin >>> 16;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ddvb_pkg::OP_CAPTURE: begin
        xc  <= voxel_x;
        yc  <= voxel_y;
        zc  <= voxel_z;
        acc <= '0;
      end
      ddvb_pkg::OP_ROT_MUL: begin
        if (cmd.idx == 3'd1) begin
          xsum <= {prod[PW-1], prod};
        end else if (cmd.idx == 3'd2) begin
          xsum <= xsum + {prod[PW-1], prod};
        end else if (cmd.idx == 3'd3) begin
          ysum <= {prod[PW-1], prod};
        end
      end
      ddvb_pkg::OP_ROT_FIN: begin
        xr <= ddvb_pkg::sat32(72'(xsum) >>> 30);
        yr <= ddvb_pkg::sat32(72'(yfin) >>> 30);
      end
      ddvb_pkg::OP_POINT: begin
        px  <= px_n;
        py  <= py_n;
        pz  <= pz_n;
        den <= 34'(px_n) + {3'b000, sad};
      end
      ddvb_pkg::OP_REC_Y: a_cur <= ddvb_pkg::sat32(72'(div_q));
      ddvb_pkg::OP_REC_Z: begin
        if (cmd.idx == 3'd0) begin
          amin <= a_cur; amax <= a_cur; bmin <= b_cur; bmax <= b_cur;
        end else begin
          if (a_cur < amin) amin <= a_cur;
          if (a_cur > amax) amax <= a_cur;
          if (b_cur < bmin) bmin <= b_cur;
          if (b_cur > bmax) bmax <= b_cur;
        end
      end
      ddvb_pkg::OP_BIN_REC: begin
        unique case (cmd.idx)
          3'd0:    umin <= bin_val;
          3'd1:    umax <= bin_val;
          3'd2:    vmin <= bin_val;
          default: vmax <= bin_val;
        endcase
      end
      ddvb_pkg::OP_WALK_INIT: begin
        priority if (ua_fl < 0) begin
          ia <= '0;
        end else if (ua_fl >= COLS_B) begin
          ia <= IA_W'(DET_COLS);
        end else begin
          ia <= ua_fl[IA_W-1:0];
        end
        priority if (vb_fl < 0) begin
          ib_start <= '0;
        end else if (vb_fl >= ROWS_B) begin
          ib_start <= IB_W'(DET_ROWS);
        end else begin
          ib_start <= vb_fl[IB_W-1:0];
        end
      end
      ddvb_pkg::OP_COL_INIT: begin
        wa   <= wa_full[ddvb_pkg::WID_W-1:0];
        ib   <= ib_start;
        addr <= AW'(ia) + AW'(AW'(ib_start) * COLS_A);
      end
      ddvb_pkg::OP_ROW_READ: wb <= wb_full[ddvb_pkg::WID_W-1:0];
      ddvb_pkg::OP_ROW_ACC: begin
        acc  <= acc + ddvb_pkg::ACC_W'(prod >>> 16);
        ib   <= ib + 1'b1;
        addr <= addr + COLS_A;
      end
      ddvb_pkg::OP_COL_NEXT:    ia <= ia + 1'b1;
      ddvb_pkg::OP_FINISH:      voxel_sum <= ddvb_pkg::sat48(acc);
      ddvb_pkg::OP_FINISH_ZERO: voxel_sum <= '0;
      default: ;
    endcase
  end

  assign status.pitch_zero = (col_pitch == '0) || (row_pitch == '0);
  assign status.den_bad    = den[33] || (den == '0);
  assign status.div_busy   = div_busy;
  assign status.col_go     = (ia < IA_W'(DET_COLS)) && (ia_q < umax);
  assign status.row_go     = (ib < IB_W'(DET_ROWS)) && (ib_q < vmax);

endmodule

// File: rtl/distance_driven_voxel_backprojector_unit.sv
// Top level of the cone-beam distance-driven voxel backprojector.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | operation, det_index, sample_value, voxel_x/y/z
//  out      | out_valid / out_stall| voxel_sum
//  cfg      | cfg_wr_en            | cfg_index, cfg_wdata
//
//  A load transaction writes one sample to the detector store. For a voxel, the
//  64-step radix-2 divider is shared by all sixteen divisions, and the walk then
//  visits each covered detector bin, column by column.
//  Reset is synchronous and clears control state and the configuration registers.
//  A finished sum waits in the output register while the next transaction is taken;
//  a second sum stalls in its last step until the first one is taken.
module distance_driven_voxel_backprojector_unit #(
  parameter int DET_COLS = ddvb_pkg::DET_COLS_DEF,
  parameter int DET_ROWS = ddvb_pkg::DET_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ddvb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [ddvb_pkg::ADDR_W-1:0]       det_index,
  input  logic signed [31:0]                sample_value,
  input  logic signed [31:0]                voxel_x,
  input  logic signed [31:0]                voxel_y,
  input  logic signed [31:0]                voxel_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ddvb_pkg::SUM_W-1:0] voxel_sum
);

  ddvb_pkg::cmd_t    cmd;
  ddvb_pkg::status_t status;

  ddvb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ddvb_datapath #(
    .DET_COLS (DET_COLS),
    .DET_ROWS (DET_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .det_index    (det_index),
    .sample_value (sample_value),
    .voxel_x      (voxel_x),
    .voxel_y      (voxel_y),
    .voxel_z      (voxel_z),
    .cmd          (cmd),
    .status       (status),
    .voxel_sum    (voxel_sum)
  );

  // no transaction is taken while a division runs
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    status.div_busy |-> in_stall)
    else $error("input taken during division");

  // a result appears only after a voxel was in work
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a voxel in work");

  // a load transaction never produces a result in the next cycle
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !operation && !out_valid) |=> !out_valid)
    else $error("load transaction produced a result");

endmodule
